// ===== rtl/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// Types and fixed constants of the debounced pulse counter.
// ----------------------------------------------------------------------------
package dpc_pkg;

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned CHAN_W   = 3;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned TICK_LO_W = 16;
	localparam int unsigned TICK_HI_W = 8;
	localparam int unsigned MASK_W   = 8;

	localparam logic [MASK_W-1:0] SAVE_MASK_RESET = 8'h15;

	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [SAMPLE_W-1:0] sample;
		logic [CHAN_W-1:0]   channel;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] edges;
		logic [SAMPLE_W-1:0] level;
		logic                save_request;
		logic [COUNT_W-1:0]  count_value;
	} result_t;

endpackage

// ===== rtl/dpc_if.sv =====
// ----------------------------------------------------------------------------
// dpc_if
// Valid/ready channels of the debounced pulse counter.
// ----------------------------------------------------------------------------
interface dpc_item_if import dpc_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dpc_result_if import dpc_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dpc_cfg_if import dpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/debounced_pulse_counter_core.sv =====
// ----------------------------------------------------------------------------
// debounced_pulse_counter_core
// Multichannel debounced pulse counter with periodic save request.
// ----------------------------------------------------------------------------
// One item is accepted every cycle unless both registers are full and the
// result is stalled. An accepted item sits in an input register, is processed
// against the ring, level and counter state in a single pass and then moves
// into the result register, from which its result is offered; a stalled
// result holds the input stage and back-pressure reaches the item channel
// only when both registers are full. Mode 0 is a sample tick, mode 1 clears
// all pulse counters and requests a save, mode 2 reads one counter; mode 3
// changes no state but still yields a result. Debounce needs WINDOW equal
// samples; save_mask may be written at any idle moment and is always ready.
// ----------------------------------------------------------------------------
module debounced_pulse_counter_core
	import dpc_pkg::*;
#(
	parameter int unsigned WINDOW       = 10,
	parameter int unsigned NUM_CHANNELS = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	dpc_item_if.sink      item_ch,
	dpc_result_if.source  result_ch,
	dpc_cfg_if.sink       cfg_ch
);

	localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

	// input stage
	logic  valid_s1;
	item_t item_s1;

	// state
	logic [SAMPLE_W-1:0]  hist_q [WINDOW];
	logic [SLOT_W-1:0]    slot_q;
	logic [SAMPLE_W-1:0]  level_q;
	logic [COUNT_W-1:0]   count_q [NUM_CHANNELS];
	logic [TICK_LO_W-1:0] tick_lo_q;
	logic [TICK_HI_W-1:0] tick_hi_q;
	logic                 changed_q;
	logic [MASK_W-1:0]    save_mask_q;

	// output stage
	logic    out_valid_q;
	result_t result_q;

	logic advance;

	logic [SAMPLE_W-1:0]  all_ones;
	logic [SAMPLE_W-1:0]  any_one;
	logic [SAMPLE_W-1:0]  level_nxt;
	logic [SAMPLE_W-1:0]  edges_nxt;
	logic [TICK_HI_W-1:0] tick_hi_inc;
	logic                 changed_nxt;
	logic                 carry;
	logic                 save_tick;
	logic [COUNT_W-1:0]   read_value;
	logic                 is_tick;
	result_t              result_nxt;

	assign advance       = valid_s1 && (!out_valid_q || result_ch.ready);
	assign item_ch.ready = !valid_s1 || advance;
	assign cfg_ch.ready  = 1'b1;
	assign is_tick       = (item_s1.mode == MODE_TICK);

	// debounce over the ring, with the current slot replaced by the new sample
	always_comb begin
		all_ones = '1;
		any_one  = '0;
		for (int k = 0; k < WINDOW; k++) begin
			if (slot_q == SLOT_W'(k)) begin
				all_ones &= item_s1.sample;
				any_one  |= item_s1.sample;
			end else begin
				all_ones &= hist_q[k];
				any_one  |= hist_q[k];
			end
		end
	end

	assign level_nxt = all_ones | (level_q & any_one);

	always_comb begin
		edges_nxt = '0;
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			edges_nxt[k] = all_ones[k] & ~level_q[k];
		end
	end

	assign changed_nxt = changed_q | (|edges_nxt);
	assign carry       = (tick_lo_q == '1);
	assign tick_hi_inc = tick_hi_q + 1'b1;
	assign save_tick   = carry && ((tick_hi_inc & save_mask_q) == '0) && changed_nxt;

	always_comb begin
		read_value = '0;
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			if (item_s1.channel == CHAN_W'(k)) begin
				read_value = count_q[k];
			end
		end
	end

	always_comb begin
		result_nxt = '0;
		result_nxt.level = level_q;
		unique case (item_s1.mode)
			MODE_TICK: begin
				result_nxt.edges        = edges_nxt;
				result_nxt.level        = level_nxt;
				result_nxt.save_request = save_tick;
			end
			MODE_CLEAR: begin
				result_nxt.save_request = 1'b1;
			end
			MODE_READ: begin
				result_nxt.count_value = read_value;
			end
			default: begin
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ch.ready) begin
			valid_s1 <= item_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ch.valid && item_ch.ready) begin
			item_s1 <= item_ch.data;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			save_mask_q <= SAVE_MASK_RESET;
		end else if (cfg_ch.valid) begin
			save_mask_q <= cfg_ch.data;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++) begin
				hist_q[k] <= '0;
			end
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				count_q[k] <= '0;
			end
			slot_q    <= '0;
			level_q   <= '0;
			tick_lo_q <= '0;
			tick_hi_q <= '0;
			changed_q <= 1'b0;
		end else if (advance) begin
			if (is_tick) begin
				for (int k = 0; k < WINDOW; k++) begin
					if (slot_q == SLOT_W'(k)) begin
						hist_q[k] <= item_s1.sample;
					end
				end
				slot_q    <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
				level_q   <= level_nxt;
				tick_lo_q <= tick_lo_q + 1'b1;
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					if (edges_nxt[k]) begin
						count_q[k] <= count_q[k] + 1'b1;
					end
				end
				if (carry) begin
					tick_hi_q <= tick_hi_inc;
				end
				// a save request consumes the pending change
				changed_q <= changed_nxt && !save_tick;
			end else if (item_s1.mode == MODE_CLEAR) begin
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					count_q[k] <= '0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.data  = result_q;

endmodule

// ===== tb/sv/debounced_pulse_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// debounced_pulse_counter_core_tb
// Self-checking bench for the debounced pulse counter core.
// A short stimulus table covers reset values, every mode and out-of-range
// reads. Random runs of steady and bouncing samples follow under several
// save masks. Each result is checked field by field against the table's
// expected value or an in-bench model of the counter.
// ----------------------------------------------------------------------------
module debounced_pulse_counter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dpc_pkg::*;

	localparam int unsigned WINDOW       = 10;
	localparam int unsigned NUM_CH       = 2;
	localparam time         CLK_PERIOD   = 10ns;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          PHASE_ITEMS  = 400;
	localparam logic [MODE_W-1:0]   MODE_UNUSED  = 2'd3;
	localparam logic [SAMPLE_W-1:0] CHANNEL_MASK = SAMPLE_W'((1 << NUM_CH) - 1);

	typedef struct packed {
		item_t      it;
		logic [7:0] reps;
		logic       known;
		result_t    want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	dpc_item_if   item_ch ();
	dpc_result_if result_ch ();
	dpc_cfg_if    cfg_ch ();

	debounced_pulse_counter_core #(
		.WINDOW       (WINDOW),
		.NUM_CHANNELS (NUM_CH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_ch   (item_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// model state
	logic [SAMPLE_W-1:0]  ring [WINDOW];
	int unsigned          ring_slot;
	logic [SAMPLE_W-1:0]  deb_level;
	logic [COUNT_W-1:0]   pulse_count [NUM_CH];
	logic [TICK_LO_W-1:0] tick_lo;
	logic [TICK_HI_W-1:0] tick_hi;
	logic                 counts_dirty;
	logic [MASK_W-1:0]    save_mask_q;

	result_t pending_results [$];
	int      fail_count  = 0;
	int      items_sent  = 0;
	int      saves_seen  = 0;
	int      idle_cycles = 0;
	int      burst_left  = 0;
	int      rx_span     = 0;
	int      rx_pct      = 0;

	dir_row_t dir_plan [0:13] = '{
		'{'{MODE_READ,   8'h00, 3'd0}, 8'd1, 1'b1, '{8'h00, 8'h00, 1'b0, 32'd0}},
		'{'{MODE_READ,   8'hFF, 3'd7}, 8'd1, 1'b1, '{8'h00, 8'h00, 1'b0, 32'd0}},
		'{'{MODE_UNUSED, 8'hFF, 3'd7}, 8'd1, 1'b1, '{8'h00, 8'h00, 1'b0, 32'd0}},
		'{'{MODE_CLEAR,  8'h00, 3'd0}, 8'd1, 1'b1, '{8'h00, 8'h00, 1'b1, 32'd0}},
		'{'{MODE_TICK,   8'hFF, 3'd0}, 8'd9, 1'b0, '0},
		'{'{MODE_TICK,   8'hFF, 3'd0}, 8'd1, 1'b1, '{8'h03, 8'hFF, 1'b0, 32'd0}},
		'{'{MODE_READ,   8'h00, 3'd0}, 8'd1, 1'b1, '{8'h00, 8'hFF, 1'b0, 32'd1}},
		'{'{MODE_READ,   8'h00, 3'd1}, 8'd1, 1'b1, '{8'h00, 8'hFF, 1'b0, 32'd1}},
		'{'{MODE_READ,   8'h00, 3'd2}, 8'd1, 1'b1, '{8'h00, 8'hFF, 1'b0, 32'd0}},
		'{'{MODE_TICK,   8'h00, 3'd0}, 8'd3, 1'b0, '0},
		'{'{MODE_CLEAR,  8'h00, 3'd0}, 8'd1, 1'b1, '{8'h00, 8'hFF, 1'b1, 32'd0}},
		'{'{MODE_READ,   8'h00, 3'd1}, 8'd1, 1'b1, '{8'h00, 8'hFF, 1'b0, 32'd0}},
		'{'{MODE_UNUSED, 8'h55, 3'd5}, 8'd1, 1'b1, '{8'h00, 8'hFF, 1'b0, 32'd0}},
		'{'{MODE_TICK,   8'h5A, 3'd0}, 8'd2, 1'b0, '0}
	};

	function automatic void clear_model();
		for (int k = 0; k < WINDOW; k++) ring[k] = '0;
		for (int k = 0; k < NUM_CH; k++) pulse_count[k] = '0;
		ring_slot    = 0;
		deb_level    = '0;
		tick_lo      = '0;
		tick_hi      = '0;
		counts_dirty = 1'b0;
		save_mask_q  = SAVE_MASK_RESET;
	endfunction

	function automatic result_t debounce_and_count(input item_t it);
		result_t             res;
		logic [SAMPLE_W-1:0] all_ones;
		logic [SAMPLE_W-1:0] any_one;
		logic [SAMPLE_W-1:0] rising;
		res = '0;
		case (it.mode)
			MODE_TICK: begin
				ring[ring_slot] = it.sample;
				ring_slot = (ring_slot + 1) % WINDOW;
				all_ones = '1;
				any_one  = '0;
				for (int k = 0; k < WINDOW; k++) begin
					all_ones &= ring[k];
					any_one  |= ring[k];
				end
				rising    = all_ones & ~deb_level;
				// falls only once the whole window reads zero
				deb_level = all_ones | (deb_level & any_one);
				res.edges = rising & CHANNEL_MASK;
				for (int k = 0; k < NUM_CH; k++) begin
					if (res.edges[k]) begin
						pulse_count[k] += 1;
						counts_dirty = 1'b1;
					end
				end
				tick_lo += 1;
				if (tick_lo == '0) begin
					tick_hi += 1;
					if ((tick_hi & save_mask_q) == '0 && counts_dirty) begin
						res.save_request = 1'b1;
						counts_dirty = 1'b0;
					end
				end
			end
			MODE_CLEAR: begin
				for (int k = 0; k < NUM_CH; k++) pulse_count[k] = '0;
				res.save_request = 1'b1;
			end
			MODE_READ: begin
				if (it.channel < NUM_CH) res.count_value = pulse_count[it.channel];
			end
			default: ;
		endcase
		res.level = deb_level;
		return res;
	endfunction

	function automatic void compare_result(input result_t want, input result_t got);
		if (got.edges !== want.edges) begin
			$error("edges: expected %h, got %h", want.edges, got.edges);
			fail_count++;
		end
		if (got.level !== want.level) begin
			$error("level: expected %h, got %h", want.level, got.level);
			fail_count++;
		end
		if (got.save_request !== want.save_request) begin
			$error("save_request: expected %b, got %b", want.save_request, got.save_request);
			fail_count++;
		end
		if (got.count_value !== want.count_value) begin
			$error("count_value: expected %h, got %h", want.count_value, got.count_value);
			fail_count++;
		end
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input item_t it, input bit known = 1'b0,
			input result_t want = '0);
		result_t pred;
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (!item_ch.ready);
		pred = debounce_and_count(it);
		pending_results.push_back(known ? want : pred);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_save_mask(input logic [MASK_W-1:0] value);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		save_mask_q = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// runs of steady samples long enough to debounce, with bounce, noise and
	// the other modes mixed in
	task automatic random_phase(input int n_items);
		int                  done;
		int                  run_len;
		int                  r;
		logic [SAMPLE_W-1:0] base;
		item_t               it;
		done = 0;
		while (done < n_items) begin
			case ($urandom_range(0, 3))
				0:       base = 8'h00;
				1:       base = 8'hFF;
				default: base = SAMPLE_W'($urandom_range(0, 255));
			endcase
			run_len = ($urandom_range(0, 9) < 7) ? $urandom_range(10, 24)
				: $urandom_range(1, 9);
			for (int k = 0; k < run_len && done < n_items; k++) begin
				r = $urandom_range(0, 99);
				it.sample  = SAMPLE_W'($urandom_range(0, 255));
				it.channel = CHAN_W'($urandom_range(0, 7));
				if (r < 84) begin
					it.mode   = MODE_TICK;
					it.sample = base;
					if ($urandom_range(0, 7) == 0) it.sample[$urandom_range(0, 7)] ^= 1'b1;
				end else if (r < 90) begin
					it.mode = MODE_READ;
				end else if (r < 93) begin
					it.mode = MODE_CLEAR;
				end else if (r < 96) begin
					it.mode = MODE_UNUSED;
				end else begin
					it.mode = MODE_TICK;
				end
				send_item(it);
				if (it.mode != MODE_UNUSED) done++;
				if ($urandom_range(0, 299) == 0) wait_drained();
				pace();
			end
		end
	endtask

	// receiver stalls: stretches of differing stall rates, fully open at times
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_span = $urandom_range(16, 96);
			case ($urandom_range(0, 2))
				0:       rx_pct = 0;
				1:       rx_pct = 30;
				default: rx_pct = 70;
			endcase
		end else begin
			rx_span--;
		end
		result_ch.ready <= ($urandom_range(0, 99) >= rx_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no item pending: %p", result_ch.data);
				fail_count++;
			end else begin
				if (result_ch.data.save_request) saves_seen++;
				compare_result(pending_results.pop_front(), result_ch.data);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		clear_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_plan[r]) begin
			for (int n = 0; n < dir_plan[r].reps; n++) begin
				send_item(dir_plan[r].it, dir_plan[r].known, dir_plan[r].want);
				pace();
			end
		end

		write_save_mask(8'h00);
		random_phase(PHASE_ITEMS);
		write_save_mask(8'hFF);
		random_phase(PHASE_ITEMS);
		write_save_mask(MASK_W'($urandom_range(1, 254)));
		random_phase(PHASE_ITEMS);

		write_save_mask(SAVE_MASK_RESET);
		random_phase(PHASE_ITEMS);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected result items never arrived", pending_results.size());
			fail_count++;
		end
		$display("Run covered %0d items: stimulus table, bouncing and steady sample runs,",
			items_sent);
		$display("clear, read and unused modes under four save masks, %0d save requests seen.",
			saves_seen);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dpc_pkg.sv
rtl/dpc_if.sv
rtl/debounced_pulse_counter_core.sv
tb/sv/debounced_pulse_counter_core_tb.sv
